### rtl/mddi_pkg.sv
package mddi_pkg;

  typedef enum logic [1:0] {
    ST_STOP = 2'd0,
    ST_FWD  = 2'd1,
    ST_BACK = 2'd2
  } drive_state_t;

  typedef enum logic [1:0] {
    CMD_STOP = 2'd0,
    CMD_FWD  = 2'd1,
    CMD_BACK = 2'd2
  } command_t;

  typedef enum logic [2:0] {
    REG_COMPARE_MIN     = 3'd0,
    REG_COMPARE_MAX     = 3'd1,
    REG_MANUAL_DUTY     = 3'd2,
    REG_COMMAND_TIMEOUT = 3'd3,
    REG_AUTO_GAIN       = 3'd4
  } reg_index_t;

  localparam int MANUAL_DUTY_W = 7;
  localparam int TIMEOUT_W     = 16;
  localparam int GAIN_W        = 8;
  localparam int SPEED_W       = 6;
  localparam int MEASURED_W    = 16;
  localparam int DUTY_W        = 7;
  localparam int RAW_DUTY_W    = SPEED_W + GAIN_W;
  localparam int FULL_DUTY     = 100;

  typedef struct packed {
    logic         manual;
    logic         auto_on;
    logic         cmd_valid;
    logic [1:0]   cmd;
    logic [SPEED_W-1:0] speed;
    logic         still;
  } item_flags_t;

  typedef struct packed {
    logic         cmp_write;
    logic         dir_write;
    logic         dir_level;
    drive_state_t state;
  } result_meta_t;

endpackage

### rtl/mddi_ctrl.sv
module mddi_ctrl
  import mddi_pkg::*;
#(
  parameter int TICK_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic [TICK_WIDTH-1:0]    now_ticks,
  input  item_flags_t              flags,
  input  logic [MANUAL_DUTY_W-1:0] manual_duty,
  input  logic [TIMEOUT_W-1:0]     command_timeout,
  input  logic [GAIN_W-1:0]        auto_gain,
  output logic [DUTY_W-1:0]        duty,
  output result_meta_t             meta
);

  drive_state_t            drive_state;
  drive_state_t            drive_state_next;
  command_t                held_command;
  command_t                held_command_next;
  logic [TICK_WIDTH-1:0]   last_command_time;
  logic [TICK_WIDTH-1:0]   last_command_time_next;
  logic [TICK_WIDTH-1:0]   elapsed;
  logic [RAW_DUTY_W-1:0]   raw_duty;
  logic                    dir_write;
  logic                    dir_level;
  logic                    duty_ok;

  always_comb begin
    held_command_next      = held_command;
    last_command_time_next = last_command_time;
    if (flags.cmd_valid) begin
      last_command_time_next = now_ticks;
      unique case (flags.cmd)
        CMD_FWD:  held_command_next = CMD_FWD;
        CMD_BACK: held_command_next = CMD_BACK;
        default:  held_command_next = CMD_STOP;
      endcase
    end
    elapsed = now_ticks - last_command_time_next;
    if (flags.manual && (elapsed > TICK_WIDTH'(command_timeout))) begin
      held_command_next = CMD_STOP;
    end

    drive_state_next = drive_state;
    raw_duty         = '0;
    dir_write        = 1'b0;
    dir_level        = 1'b0;
    priority if (flags.manual) begin
      unique case (drive_state)
        ST_STOP: begin
          if (held_command_next == CMD_FWD) begin
            raw_duty         = RAW_DUTY_W'(manual_duty);
            dir_write        = 1'b1;
            drive_state_next = ST_FWD;
          end else if (held_command_next == CMD_BACK) begin
            raw_duty         = RAW_DUTY_W'(manual_duty);
            dir_write        = 1'b1;
            dir_level        = 1'b1;
            drive_state_next = ST_BACK;
          end
        end
        ST_FWD: begin
          if (held_command_next == CMD_FWD) begin
            raw_duty  = RAW_DUTY_W'(manual_duty);
            dir_write = 1'b1;
          end else if (flags.still) begin
            drive_state_next = ST_STOP;
          end
        end
        ST_BACK: begin
          if (held_command_next == CMD_BACK) begin
            raw_duty  = RAW_DUTY_W'(manual_duty);
            dir_write = 1'b1;
            dir_level = 1'b1;
          end else if (flags.still) begin
            drive_state_next = ST_STOP;
          end
        end
        default: drive_state_next = drive_state;
      endcase
    end else if (flags.auto_on) begin
      raw_duty  = RAW_DUTY_W'(flags.speed) * RAW_DUTY_W'(auto_gain);
      dir_write = 1'b1;
    end else begin
      raw_duty = '0;
    end
    duty_ok = (raw_duty <= RAW_DUTY_W'(FULL_DUTY));
  end

  assign duty           = duty_ok ? raw_duty[DUTY_W-1:0] : '0;
  assign meta.cmp_write = duty_ok;
  assign meta.dir_write = dir_write;
  assign meta.dir_level = dir_level;
  assign meta.state     = drive_state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      drive_state       <= ST_STOP;
      held_command      <= CMD_STOP;
      last_command_time <= '0;
    end else if (advance) begin
      drive_state       <= drive_state_next;
      held_command      <= held_command_next;
      last_command_time <= last_command_time_next;
    end
  end

  a_no_fwd_to_back: assert property (@(posedge clk) disable iff (rst)
    (advance && drive_state == ST_FWD) |=> (drive_state != ST_BACK))
    else $error("forward went straight to backward");

  a_no_back_to_fwd: assert property (@(posedge clk) disable iff (rst)
    (advance && drive_state == ST_BACK) |=> (drive_state != ST_FWD))
    else $error("backward went straight to forward");

  a_moving_holds: assert property (@(posedge clk) disable iff (rst)
    (advance && drive_state == ST_FWD && !flags.still) |=> (drive_state == ST_FWD))
    else $error("forward left while still moving");

  a_auto_keeps_state: assert property (@(posedge clk) disable iff (rst)
    (advance && !flags.manual) |=> $stable(drive_state))
    else $error("drive state changed outside manual mode");

endmodule

### rtl/mddi_scale.sv
module mddi_scale
  import mddi_pkg::*;
#(
  parameter int COMPARE_WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [DUTY_W-1:0]        in_duty,
  input  result_meta_t             in_meta,
  input  logic [COMPARE_WIDTH-1:0] compare_min,
  input  logic [COMPARE_WIDTH-1:0] compare_max,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [COMPARE_WIDTH-1:0] out_value,
  output result_meta_t             out_meta
);

  localparam int CW       = COMPARE_WIDTH;
  localparam int QW       = CW - 6;
  localparam int PW       = 2 * CW + 1;
  localparam int RSHIFT   = CW + 7;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RSHIFT) + 64'd99) / 64'd100;
  localparam logic [CW:0] RECIP      = RECIP_FULL[CW:0];
  localparam int PART_W   = 2 * DUTY_W;
  localparam int SMALL_MUL   = 5243;
  localparam int SMALL_SHIFT = 19;
  localparam int SMALL_PW    = PART_W + 13;

  logic               va, vb, vc, vd;
  logic               en_a, en_b, en_c, en_d, en_e;
  logic [CW-1:0]      span_a, span_b;
  logic [DUTY_W-1:0]  duty_a, duty_b, duty_c;
  result_meta_t       meta_a, meta_b, meta_c, meta_d;
  logic [QW-1:0]      sq_b, sq_c;
  logic [DUTY_W-1:0]  sr_c;
  logic [CW-1:0]      whole_d;
  logic [PART_W-1:0]  part_d;
  logic [PW-1:0]      prod;
  logic [CW-1:0]      rem_full;
  logic [SMALL_PW-1:0] small_prod;

  assign en_e     = !out_valid || out_ready;
  assign en_d     = !vd || en_e;
  assign en_c     = !vc || en_d;
  assign en_b     = !vb || en_c;
  assign en_a     = !va || en_b;
  assign in_ready = en_a;

  assign prod       = PW'(span_a) * PW'(RECIP);
  assign rem_full   = span_b - (CW'(sq_b) * CW'(FULL_DUTY));
  assign small_prod = SMALL_PW'(part_d) * SMALL_PW'(SMALL_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= 1'b0;
      vb        <= 1'b0;
      vc        <= 1'b0;
      vd        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_a) va <= in_valid;
      if (en_b) vb <= va;
      if (en_c) vc <= vb;
      if (en_d) vd <= vc;
      if (en_e) out_valid <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      span_a <= compare_max - compare_min;
      duty_a <= in_duty;
      meta_a <= in_meta;
    end
    if (en_b) begin
      sq_b   <= prod[PW-1:RSHIFT];
      span_b <= span_a;
      duty_b <= duty_a;
      meta_b <= meta_a;
    end
    if (en_c) begin
      sq_c   <= sq_b;
      sr_c   <= rem_full[DUTY_W-1:0];
      duty_c <= duty_b;
      meta_c <= meta_b;
    end
    if (en_d) begin
      whole_d <= CW'(sq_c) * CW'(duty_c);
      part_d  <= PART_W'(sr_c) * PART_W'(duty_c);
      meta_d  <= meta_c;
    end
    if (en_e) begin
      out_value <= meta_d.cmp_write
                   ? compare_min + whole_d + CW'(small_prod[SMALL_PW-1:SMALL_SHIFT])
                   : '0;
      out_meta  <= meta_d;
    end
  end

  a_zero_when_no_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_meta.cmp_write) |-> (out_value == '0))
    else $error("compare value set without a compare write");

  a_rem_below_hundred: assert property (@(posedge clk) disable iff (rst)
    vc |-> (sr_c < DUTY_W'(FULL_DUTY)))
    else $error("remainder out of range");

endmodule

### rtl/motor_drive_direction_interlock_unit.sv
// An accepted item passes the input register and the five-stage compare scaling
// pipeline before its result is presented. Throughput: one item per cycle unless
// m_tready stalls the output; the input register, the drive state update and the
// scaling pipeline each take a new item every cycle. Configuration writes are
// taken every cycle. Reset (rst, synchronous): drive state stopped, stored
// command stop, command time zero, registers to their defaults, pipeline empty.
module motor_drive_direction_interlock_unit
  import mddi_pkg::*;
#(
  parameter int COMPARE_WIDTH = 16,
  parameter int TICK_WIDTH    = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // now_ticks, manual_mode, auto_mode, command_valid, manual_command,
  // requested_speed, measured_speed
  input  logic [((TICK_WIDTH+27+7)/8)*8-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // compare_write, compare_value, direction_write, direction_level, drive_state_out
  output logic [((COMPARE_WIDTH+5+7)/8)*8-1:0] m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [(COMPARE_WIDTH > 16 ? COMPARE_WIDTH : 16)-1:0] cfg_data
);

  localparam int TW      = TICK_WIDTH;
  localparam int CW      = COMPARE_WIDTH;
  localparam int OUT_W   = ((CW + 5 + 7) / 8) * 8;
  localparam int OFS_MAN = TW;
  localparam int OFS_AUT = TW + 1;
  localparam int OFS_CV  = TW + 2;
  localparam int OFS_CMD = TW + 3;
  localparam int OFS_SPD = TW + 5;
  localparam int OFS_MEA = OFS_SPD + SPEED_W;

  logic [CW-1:0]            compare_min;
  logic [CW-1:0]            compare_max;
  logic [MANUAL_DUTY_W-1:0] manual_duty;
  logic [TIMEOUT_W-1:0]     command_timeout;
  logic [GAIN_W-1:0]        auto_gain;

  logic                     v0;
  logic [TW-1:0]            now_ticks;
  item_flags_t              flags;
  logic                     scale_ready;
  logic                     advance;
  logic [DUTY_W-1:0]        duty;
  result_meta_t             meta;
  logic [CW-1:0]            out_value;
  result_meta_t             out_meta;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      compare_min     <= '0;
      compare_max     <= CW'(32'd65535);
      manual_duty     <= MANUAL_DUTY_W'(30);
      command_timeout <= TIMEOUT_W'(500);
      auto_gain       <= GAIN_W'(5);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_COMPARE_MIN:     compare_min     <= cfg_data[CW-1:0];
        REG_COMPARE_MAX:     compare_max     <= cfg_data[CW-1:0];
        REG_MANUAL_DUTY:     manual_duty     <= cfg_data[MANUAL_DUTY_W-1:0];
        REG_COMMAND_TIMEOUT: command_timeout <= cfg_data[TIMEOUT_W-1:0];
        REG_AUTO_GAIN:       auto_gain       <= cfg_data[GAIN_W-1:0];
        default:             compare_min     <= compare_min;
      endcase
    end
  end

  assign s_tready = !v0 || scale_ready;
  assign advance  = v0 && scale_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (s_tready) begin
      v0 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      now_ticks       <= s_tdata[TW-1:0];
      flags.manual    <= s_tdata[OFS_MAN];
      flags.auto_on   <= s_tdata[OFS_AUT];
      flags.cmd_valid <= s_tdata[OFS_CV];
      flags.cmd       <= s_tdata[OFS_CMD+1:OFS_CMD];
      flags.speed     <= s_tdata[OFS_SPD+SPEED_W-1:OFS_SPD];
      flags.still     <= (s_tdata[OFS_MEA+MEASURED_W-1:OFS_MEA] == '0);
    end
  end

  mddi_ctrl #(
    .TICK_WIDTH(TW)
  ) u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .advance         (advance),
    .now_ticks       (now_ticks),
    .flags           (flags),
    .manual_duty     (manual_duty),
    .command_timeout (command_timeout),
    .auto_gain       (auto_gain),
    .duty            (duty),
    .meta            (meta)
  );

  mddi_scale #(
    .COMPARE_WIDTH(CW)
  ) u_scale (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (v0),
    .in_ready    (scale_ready),
    .in_duty     (duty),
    .in_meta     (meta),
    .compare_min (compare_min),
    .compare_max (compare_max),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_value   (out_value),
    .out_meta    (out_meta)
  );

  assign m_tdata = OUT_W'({out_meta.state, out_meta.dir_level, out_meta.dir_write,
                           out_value, out_meta.cmp_write});

endmodule

### test/tb_motor_drive_direction_interlock_unit.sv
`timescale 1ns / 1ps

module tb_motor_drive_direction_interlock_unit;
  import mddi_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [31:0] now;
    logic        manual;
    logic        auto_on;
    logic        cmd_valid;
    logic [1:0]  cmd;
    logic [5:0]  speed;
    logic [15:0] measured;
  } motor_item_t;

  typedef struct packed {
    logic         cmp_write;
    logic [15:0]  cmp_value;
    logic         dir_write;
    logic         dir_level;
    drive_state_t state;
  } drive_result_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  motor_drive_direction_interlock_unit dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // shadow of the block's registers and drive state
  logic [15:0]  cfg_min;
  logic [15:0]  cfg_max;
  logic [6:0]   cfg_mduty;
  logic [15:0]  cfg_timeout;
  logic [7:0]   cfg_gain;
  drive_state_t drive_st;
  command_t     held_cmd;
  logic [31:0]  last_cmd_time;

  drive_result_t pending_drive_q[$];
  logic [31:0]   tick_now;
  int            items_sent;
  int            results_checked;
  int            reg_writes;
  int            fault_count;
  int            sink_hold_req;
  bit            burst_mode;
  bit            sink_steady;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("motor_drive_direction_interlock_unit regression: fail");
    $finish;
  end

  function automatic int pick_gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic drive_result_t apply_duty(drive_result_t r, int unsigned duty);
    logic [15:0] span;
    if (duty > FULL_DUTY) return r;
    span = cfg_max - cfg_min;
    r.cmp_write = 1'b1;
    r.cmp_value = cfg_min + 16'((32'(span) * duty) / FULL_DUTY);
    return r;
  endfunction

  function automatic drive_result_t apply_dir(drive_result_t r, logic backward);
    r.dir_write = 1'b1;
    r.dir_level = backward;
    return r;
  endfunction

  function automatic drive_result_t predict_drive_step(motor_item_t it);
    drive_result_t r;
    logic [31:0]   elapsed;
    r = '0;
    if (it.cmd_valid) begin
      held_cmd = (it.cmd == CMD_UNUSED) ? CMD_STOP : command_t'(it.cmd);
      last_cmd_time = it.now;
    end
    if (it.manual) begin
      elapsed = it.now - last_cmd_time;
      if (elapsed > {16'd0, cfg_timeout}) held_cmd = CMD_STOP;
      case (drive_st)
        ST_STOP: begin
          if (held_cmd == CMD_FWD) begin
            r = apply_dir(apply_duty(r, cfg_mduty), 1'b0);
            drive_st = ST_FWD;
          end else if (held_cmd == CMD_BACK) begin
            r = apply_dir(apply_duty(r, cfg_mduty), 1'b1);
            drive_st = ST_BACK;
          end else begin
            r = apply_duty(r, 0);
          end
        end
        ST_FWD: begin
          if (held_cmd == CMD_FWD) begin
            r = apply_dir(apply_duty(r, cfg_mduty), 1'b0);
          end else begin
            r = apply_duty(r, 0);
            if (it.measured == '0) drive_st = ST_STOP;
          end
        end
        default: begin
          if (held_cmd == CMD_BACK) begin
            r = apply_dir(apply_duty(r, cfg_mduty), 1'b1);
          end else begin
            r = apply_duty(r, 0);
            if (it.measured == '0) drive_st = ST_STOP;
          end
        end
      endcase
    end else if (it.auto_on) begin
      r = apply_dir(apply_duty(r, int'(it.speed) * int'(cfg_gain)), 1'b0);
    end else begin
      r = apply_duty(r, 0);
    end
    r.state = drive_st;
    return r;
  endfunction

  function automatic motor_item_t mk_item(logic [31:0] now, logic man, logic au, logic cv,
                                          logic [1:0] cmd, logic [5:0] spd,
                                          logic [15:0] meas);
    motor_item_t it;
    it.now = now;
    it.manual = man;
    it.auto_on = au;
    it.cmd_valid = cv;
    it.cmd = cmd;
    it.speed = spd;
    it.measured = meas;
    return it;
  endfunction

  function automatic motor_item_t random_drive_item();
    motor_item_t it;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) tick_now = tick_now + $urandom_range(0, 12);
    else if (r < 95)
      tick_now = tick_now + $urandom_range(0, int'(cfg_timeout) + int'(cfg_timeout) / 2 + 2);
    else tick_now = $urandom;
    it.now = tick_now;
    r = $urandom_range(0, 99);
    it.manual = r < 65;
    it.auto_on = r >= 55 && r < 90;
    it.cmd_valid = $urandom_range(0, 99) < 30;
    it.cmd = ($urandom_range(0, 99) < 5) ? CMD_UNUSED : 2'($urandom_range(0, 2));
    it.speed = 6'($urandom_range(0, 51));
    it.measured = $urandom_range(0, 1) ? 16'd0 : 16'($urandom);
    return it;
  endfunction

  task automatic send_drive_item(motor_item_t it);
    int gap;
    gap = (burst_mode || $urandom_range(0, 99) < 60) ? 0 : pick_gap_len();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = '0;
    s_tdata[31:0] = it.now;
    s_tdata[32] = it.manual;
    s_tdata[33] = it.auto_on;
    s_tdata[34] = it.cmd_valid;
    s_tdata[36:35] = it.cmd;
    s_tdata[42:37] = it.speed;
    s_tdata[58:43] = it.measured;
    do @(posedge clk); while (!s_tready);
    pending_drive_q.push_back(predict_drive_step(it));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_drive_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_COMPARE_MIN:     cfg_min = val;
      REG_COMPARE_MAX:     cfg_max = val;
      REG_MANUAL_DUTY:     cfg_mduty = val[6:0];
      REG_COMMAND_TIMEOUT: cfg_timeout = val;
      REG_AUTO_GAIN:       cfg_gain = val[7:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_settings(logic [15:0] cmin, logic [15:0] cmax, logic [15:0] mduty,
                                logic [15:0] tmo, logic [15:0] gain);
    wait_idle();
    write_reg(REG_COMPARE_MIN, cmin);
    write_reg(REG_COMPARE_MAX, cmax);
    write_reg(REG_MANUAL_DUTY, mduty);
    write_reg(REG_COMMAND_TIMEOUT, tmo);
    write_reg(REG_AUTO_GAIN, gain);
  endtask

  task automatic test_directed_interlock();
    send_drive_item(mk_item(32'd0, 1, 0, 0, CMD_STOP, 0, 0));
    send_drive_item(mk_item(32'd10, 1, 0, 1, CMD_FWD, 0, 0));
    send_drive_item(mk_item(32'd20, 1, 0, 0, CMD_STOP, 0, 5));
    send_drive_item(mk_item(32'd30, 1, 0, 1, CMD_BACK, 0, 5));
    send_drive_item(mk_item(32'd40, 1, 0, 0, CMD_STOP, 0, 0));
    send_drive_item(mk_item(32'd50, 1, 0, 0, CMD_STOP, 0, 0));
    send_drive_item(mk_item(32'd60, 1, 0, 1, CMD_UNUSED, 0, 16'hFFFF));
    send_drive_item(mk_item(32'd70, 1, 0, 1, CMD_FWD, 0, 0));
    send_drive_item(mk_item(32'd80, 1, 0, 0, CMD_STOP, 0, 0));
    send_drive_item(mk_item(32'd581, 1, 0, 0, CMD_STOP, 0, 7));
    send_drive_item(mk_item(32'd582, 1, 0, 1, CMD_FWD, 0, 0));
    send_drive_item(mk_item(32'd1082, 1, 0, 0, CMD_STOP, 0, 0));
    send_drive_item(mk_item(32'd1100, 0, 1, 0, CMD_STOP, 51, 0));
    send_drive_item(mk_item(32'd1101, 0, 1, 0, CMD_STOP, 20, 0));
    send_drive_item(mk_item(32'd1102, 0, 1, 0, CMD_STOP, 0, 0));
    send_drive_item(mk_item(32'd1103, 0, 0, 0, CMD_STOP, 51, 0));
    send_drive_item(mk_item(32'd1104, 1, 1, 1, CMD_BACK, 51, 0));
    send_drive_item(mk_item(32'hFFFF_FFF0, 1, 0, 1, CMD_BACK, 0, 0));
    send_drive_item(mk_item(32'h0000_0010, 1, 0, 0, CMD_STOP, 0, 0));
    send_drive_item(mk_item(32'hFFFF_FFFF, 1, 0, 0, CMD_STOP, 0, 0));
    send_drive_item(mk_item(32'hFFFF_FFFF, 0, 1, 1, CMD_FWD, 51, 16'hFFFF));
    send_drive_item(mk_item(32'd0, 1, 0, 0, CMD_STOP, 0, 0));
    send_drive_item(mk_item(32'd0, 1, 0, 0, CMD_STOP, 0, 0));
    send_drive_item(mk_item(32'h0000_0400, 0, 0, 1, CMD_BACK, 6'h2A, 16'h5555));
  endtask

  task automatic test_register_sweep();
    logic [15:0] row [6][5];
    row[0] = '{16'd0, 16'd65535, 16'd30, 16'd500, 16'd5};
    row[1] = '{16'd0, 16'd65535, 16'd100, 16'd0, 16'd255};
    row[2] = '{16'd65535, 16'd0, 16'd0, 16'd65535, 16'd0};
    row[3] = '{16'd1000, 16'd50000, 16'd55, 16'd40, 16'd2};
    row[4] = '{16'd40000, 16'd1200, 16'd100, 16'd25, 16'd20};
    row[5] = '{16'($urandom), 16'($urandom), 16'($urandom_range(0, 100)),
               16'($urandom_range(0, 300)), 16'($urandom_range(0, 255))};
    for (int p = 0; p < 6; p++) begin
      apply_settings(row[p][0], row[p][1], row[p][2], row[p][3], row[p][4]);
      tick_now = $urandom;
      repeat (250) send_drive_item(random_drive_item());
    end
  endtask

  task automatic test_output_backpressure();
    wait_idle();
    burst_mode = 1'b1;
    sink_hold_req = 150;
    repeat (60) send_drive_item(random_drive_item());
    burst_mode = 1'b0;
  endtask

  task automatic test_back_to_back();
    apply_settings(16'd100, 16'd60000, 16'd75, 16'd60, 16'd3);
    burst_mode = 1'b1;
    sink_steady = 1'b1;
    repeat (250) send_drive_item(random_drive_item());
    burst_mode = 1'b0;
    sink_steady = 1'b0;
  endtask

  initial begin
    int hold_left;
    int stall_left;
    hold_left = 0;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold_req > 0) begin
        hold_left = sink_hold_req;
        sink_hold_req = 0;
      end
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap_len() - 1;
        m_tready = 1'b0;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    drive_result_t got;
    drive_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.cmp_write = m_tdata[0];
      got.cmp_value = m_tdata[16:1];
      got.dir_write = m_tdata[17];
      got.dir_level = m_tdata[18];
      got.state = drive_state_t'(m_tdata[20:19]);
      results_checked++;
      if (pending_drive_q.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("[%0t] result with no item outstanding: cw=%0b cv=%0d dw=%0b dl=%0b st=%0d",
                   $realtime, got.cmp_write, got.cmp_value, got.dir_write, got.dir_level,
                   got.state);
      end else begin
        want = pending_drive_q.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= 10)
            $display("[%0t] mismatch: expected cw=%0b cv=%0d dw=%0b dl=%0b st=%0d, got cw=%0b cv=%0d dw=%0b dl=%0b st=%0d",
                     $realtime, want.cmp_write, want.cmp_value, want.dir_write,
                     want.dir_level, want.state, got.cmp_write, got.cmp_value,
                     got.dir_write, got.dir_level, got.state);
        end
      end
    end
  end

  initial begin
    int drain;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_COMPARE_MIN;
    cfg_data = '0;
    cfg_min = 16'd0;
    cfg_max = 16'd65535;
    cfg_mduty = 7'd30;
    cfg_timeout = 16'd500;
    cfg_gain = 8'd5;
    drive_st = ST_STOP;
    held_cmd = CMD_STOP;
    last_cmd_time = '0;
    tick_now = '0;
    items_sent = 0;
    results_checked = 0;
    reg_writes = 0;
    fault_count = 0;
    sink_hold_req = 0;
    burst_mode = 1'b0;
    sink_steady = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_interlock();
    test_register_sweep();
    test_output_backpressure();
    test_back_to_back();

    @(negedge clk);
    s_tvalid = 1'b0;
    drain = 0;
    while (pending_drive_q.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (20) @(posedge clk);
    if (pending_drive_q.size() != 0) begin
      $display("%0d expected results never arrived", pending_drive_q.size());
      fault_count += pending_drive_q.size();
    end

    $display("Drove %0d items through %0d register writes and compared %0d results,",
             items_sent, reg_writes, results_checked);
    $display("covering manual reversals, timeouts, automatic overrange, and output stalls.");
    if (fault_count == 0) begin
      $display("motor_drive_direction_interlock_unit regression: pass");
    end else begin
      $display("%0d faults", fault_count);
      $display("motor_drive_direction_interlock_unit regression: fail");
    end
    $finish;
  end

endmodule
